// ===== sv/tlbpt_pkg.sv =====
// Shared constants, types and sequencer states of the page translation block.
`timescale 1ns / 1ps
`default_nettype none
package tlbpt_pkg;

	localparam int TLB_ENTRIES = 16;
	localparam int PAGE_COUNT  = 1024;
	localparam int FRAME_COUNT = 256;
	localparam int OFFSET_BITS = 10;
	localparam int ADDR_BITS   = 20;
	localparam int PAGE_BITS   = 10;
	localparam int FRAME_BITS  = 8;
	localparam int TLB_BITS    = 4;
	localparam int PHYS_BITS   = 18;
	localparam int COUNT_BITS  = 9;
	localparam int IN_BYTES_W  = 24;
	localparam int OUT_BYTES_W = 32;

	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_LRU  = 1'b1;

	typedef logic [PAGE_BITS-1:0]   page_t;
	typedef logic [FRAME_BITS-1:0]  frame_t;
	typedef logic [FRAME_BITS-1:0]  rank_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [TLB_BITS-1:0]    tlb_idx_t;

	// Page map entry: valid bit on top of the frame number.
	typedef struct packed {
		logic   valid;
		frame_t frame;
	} pm_entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TLB,
		ST_PM_CHK,
		ST_LRU_SCAN,
		ST_OWN_RD,
		ST_OWN_CHK,
		ST_MAP_WR,
		ST_TLB_FILL,
		ST_R_RD,
		ST_R_GET,
		ST_TOUCH_SCAN,
		ST_TOUCH_END,
		ST_FINISH
	} state_t;

endpackage
`default_nettype wire

// ===== sv/tlb_page_translation_with_replacement.sv =====
// Top level: TLB lookup, demand paging with FIFO or LRU replacement, recency upkeep.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  s       | s_tvalid, s_tready, s_tdata (address)     | in
//  m       | m_tvalid, m_tready, m_tdata (translation) | out
//  cfg     | cfg_wr_en, cfg_wr_data (replace_mode)     | in
//
// After reset the page map is cleared before the first beat is taken.
// A result is loaded after the TLB lookup, on a miss the page map check and on a fault the
// frame pick and the map write, then the recency walk through the rank memory, one frame a
// cycle over the frames in use after the access, and the rank write. An eviction also reads
// the old owner and its walk covers all 256 frames; in LRU mode a victim scan of all 256
// frames of the same memory comes first. A finished result waits in the output register
// while the next beat is taken; only the final step waits on m_tready.
`timescale 1ns / 1ps
`default_nettype none
module tlb_page_translation_with_replacement (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [19:0] logical_addr
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [17:0] phys_addr, [18] tlb_hit, [19] page_fault, [20] evicted_valid,
	// [30:21] evicted_page
	output logic [31:0]      m_tdata,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data
);

	tlbpt_pkg::state_t state_q, state_d;

	logic mode_q;

	// TLB registers
	logic               tlb_vld_q [tlbpt_pkg::TLB_ENTRIES];
	tlbpt_pkg::page_t   tlb_page_q [tlbpt_pkg::TLB_ENTRIES];
	tlbpt_pkg::frame_t  tlb_frame_q [tlbpt_pkg::TLB_ENTRIES];
	tlbpt_pkg::tlb_idx_t tlb_ptr_q;

	// Memories
	tlbpt_pkg::pm_entry_t pm_mem [tlbpt_pkg::PAGE_COUNT];
	tlbpt_pkg::page_t     own_mem [tlbpt_pkg::FRAME_COUNT];
	tlbpt_pkg::rank_t     rank_mem [tlbpt_pkg::FRAME_COUNT];
	tlbpt_pkg::pm_entry_t pm_rd_q;
	tlbpt_pkg::page_t     own_rd_q;
	tlbpt_pkg::rank_t     rank_rd_q;

	logic                 pm_we;
	tlbpt_pkg::page_t     pm_waddr, pm_raddr;
	tlbpt_pkg::pm_entry_t pm_wdata;
	logic                 own_we;
	tlbpt_pkg::frame_t    own_raddr;
	logic                 rank_we;
	tlbpt_pkg::frame_t    rank_waddr, rank_raddr;
	tlbpt_pkg::rank_t     rank_wdata;

	// Control counters
	tlbpt_pkg::page_t  clr_q;
	tlbpt_pkg::count_t free_q;
	tlbpt_pkg::frame_t fifo_q;
	tlbpt_pkg::count_t scan_q;
	logic              pend_s1;
	tlbpt_pkg::frame_t idx_s1;
	tlbpt_pkg::count_t used;
	tlbpt_pkg::count_t scan_lim;
	logic              scan_done;

	// Item registers
	tlbpt_pkg::page_t   page_q;
	tlbpt_pkg::offset_t off_q;
	tlbpt_pkg::frame_t  frame_q;
	tlbpt_pkg::rank_t   r_q;
	tlbpt_pkg::frame_t  best_q;
	tlbpt_pkg::rank_t   best_rank_q;
	logic               hit_q, fault_q, ev_q;
	tlbpt_pkg::page_t   evpage_q;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        s_acc, out_load;

	// TLB lookup and frame match
	logic              tlb_hit;
	tlbpt_pkg::frame_t tlb_hit_frame;
	logic              fr_match;
	tlbpt_pkg::tlb_idx_t fr_idx;

	assign used      = tlbpt_pkg::count_t'(tlbpt_pkg::FRAME_COUNT) - free_q;
	assign scan_lim  = (state_q == tlbpt_pkg::ST_LRU_SCAN) ?
		tlbpt_pkg::count_t'(tlbpt_pkg::FRAME_COUNT) : used;
	assign scan_done = (scan_q == scan_lim) && !pend_s1;
	assign s_acc     = s_tvalid && s_tready;
	assign out_load  = (state_q == tlbpt_pkg::ST_FINISH) && (!m_tvalid_q || m_tready);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_comb begin
		tlb_hit       = 1'b0;
		tlb_hit_frame = '0;
		fr_match      = 1'b0;
		fr_idx        = '0;
		for (int i = tlbpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
			if (tlb_vld_q[i] && tlb_page_q[i] == page_q) begin
				tlb_hit       = 1'b1;
				tlb_hit_frame = tlb_frame_q[i];
			end
			if (tlb_vld_q[i] && tlb_frame_q[i] == frame_q) begin
				fr_match = 1'b1;
				fr_idx   = tlbpt_pkg::tlb_idx_t'(i);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tlbpt_pkg::ST_CLEAR: begin
				if (clr_q == tlbpt_pkg::page_t'(tlbpt_pkg::PAGE_COUNT - 1))
					state_d = tlbpt_pkg::ST_IDLE;
			end
			tlbpt_pkg::ST_IDLE: begin
				if (s_acc)
					state_d = tlbpt_pkg::ST_TLB;
			end
			tlbpt_pkg::ST_TLB: begin
				state_d = tlb_hit ? tlbpt_pkg::ST_R_RD : tlbpt_pkg::ST_PM_CHK;
			end
			tlbpt_pkg::ST_PM_CHK: begin
				if (pm_rd_q.valid)
					state_d = tlbpt_pkg::ST_TLB_FILL;
				else if (free_q != '0)
					state_d = tlbpt_pkg::ST_MAP_WR;
				else if (mode_q == tlbpt_pkg::MODE_LRU)
					state_d = tlbpt_pkg::ST_LRU_SCAN;
				else
					state_d = tlbpt_pkg::ST_OWN_RD;
			end
			tlbpt_pkg::ST_LRU_SCAN: begin
				if (scan_done)
					state_d = tlbpt_pkg::ST_OWN_RD;
			end
			tlbpt_pkg::ST_OWN_RD:     state_d = tlbpt_pkg::ST_OWN_CHK;
			tlbpt_pkg::ST_OWN_CHK:    state_d = tlbpt_pkg::ST_MAP_WR;
			tlbpt_pkg::ST_MAP_WR:     state_d = tlbpt_pkg::ST_TLB_FILL;
			tlbpt_pkg::ST_TLB_FILL:   state_d = tlbpt_pkg::ST_R_RD;
			tlbpt_pkg::ST_R_RD:       state_d = tlbpt_pkg::ST_R_GET;
			tlbpt_pkg::ST_R_GET:      state_d = tlbpt_pkg::ST_TOUCH_SCAN;
			tlbpt_pkg::ST_TOUCH_SCAN: begin
				if (scan_done)
					state_d = tlbpt_pkg::ST_TOUCH_END;
			end
			tlbpt_pkg::ST_TOUCH_END:  state_d = tlbpt_pkg::ST_FINISH;
			tlbpt_pkg::ST_FINISH: begin
				if (out_load)
					state_d = tlbpt_pkg::ST_IDLE;
			end
			default: state_d = tlbpt_pkg::ST_IDLE;
		endcase
	end

	// Memory ports and handshake
	always_comb begin
		s_tready   = 1'b0;
		pm_we      = 1'b0;
		pm_waddr   = page_q;
		pm_wdata   = '0;
		pm_raddr   = page_q;
		own_we     = 1'b0;
		own_raddr  = frame_q;
		rank_we    = 1'b0;
		rank_waddr = frame_q;
		rank_wdata = '0;
		rank_raddr = frame_q;
		unique case (state_q)
			tlbpt_pkg::ST_CLEAR: begin
				pm_we    = 1'b1;
				pm_waddr = clr_q;
			end
			tlbpt_pkg::ST_IDLE: s_tready = 1'b1;
			tlbpt_pkg::ST_PM_CHK: begin
				if (!pm_rd_q.valid && free_q != '0) begin
					rank_we    = 1'b1;
					rank_waddr = used[tlbpt_pkg::FRAME_BITS-1:0];
					rank_wdata = used[tlbpt_pkg::FRAME_BITS-1:0];
				end
			end
			tlbpt_pkg::ST_LRU_SCAN: rank_raddr = scan_q[tlbpt_pkg::FRAME_BITS-1:0];
			tlbpt_pkg::ST_OWN_CHK: begin
				pm_we    = 1'b1;
				pm_waddr = own_rd_q;
			end
			tlbpt_pkg::ST_MAP_WR: begin
				pm_we    = 1'b1;
				pm_wdata = '{valid: 1'b1, frame: frame_q};
				own_we   = 1'b1;
			end
			tlbpt_pkg::ST_TOUCH_SCAN: begin
				rank_raddr = scan_q[tlbpt_pkg::FRAME_BITS-1:0];
				// Frames more recent than the touched one age by one.
				if (pend_s1 && idx_s1 != frame_q && rank_rd_q < r_q) begin
					rank_we    = 1'b1;
					rank_waddr = idx_s1;
					rank_wdata = rank_rd_q + tlbpt_pkg::rank_t'(1);
				end
			end
			tlbpt_pkg::ST_TOUCH_END: rank_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pm_we)
			pm_mem[pm_waddr] <= pm_wdata;
		pm_rd_q <= pm_mem[pm_raddr];
	end

	always_ff @(posedge clk) begin
		if (own_we)
			own_mem[frame_q] <= page_q;
		own_rd_q <= own_mem[own_raddr];
	end

	always_ff @(posedge clk) begin
		if (rank_we)
			rank_mem[rank_waddr] <= rank_wdata;
		rank_rd_q <= rank_mem[rank_raddr];
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tlbpt_pkg::ST_CLEAR;
			mode_q     <= tlbpt_pkg::MODE_FIFO;
			tlb_ptr_q  <= '0;
			clr_q      <= '0;
			free_q     <= tlbpt_pkg::count_t'(tlbpt_pkg::FRAME_COUNT);
			fifo_q     <= '0;
			scan_q     <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
				tlb_vld_q[i] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				mode_q <= cfg_wr_data;
			if (state_q == tlbpt_pkg::ST_CLEAR)
				clr_q <= clr_q + tlbpt_pkg::page_t'(1);
			if (state_q == tlbpt_pkg::ST_PM_CHK && !pm_rd_q.valid) begin
				fifo_q <= fifo_q + tlbpt_pkg::frame_t'(1);
				if (free_q != '0)
					free_q <= free_q - tlbpt_pkg::count_t'(1);
			end
			if (state_q == tlbpt_pkg::ST_TLB_FILL && !fr_match) begin
				tlb_vld_q[tlb_ptr_q] <= 1'b1;
				tlb_ptr_q <= tlb_ptr_q + tlbpt_pkg::tlb_idx_t'(1);
			end
			if (state_d == tlbpt_pkg::ST_LRU_SCAN && state_q != tlbpt_pkg::ST_LRU_SCAN ||
			    state_q == tlbpt_pkg::ST_R_GET) begin
				scan_q  <= '0;
				pend_s1 <= 1'b0;
			end else if (scan_q < scan_lim) begin
				scan_q  <= scan_q + tlbpt_pkg::count_t'(1);
				pend_s1 <= 1'b1;
			end else begin
				pend_s1 <= 1'b0;
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[tlbpt_pkg::FRAME_BITS-1:0];
		if (s_acc) begin
			page_q   <= s_tdata[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS];
			off_q    <= s_tdata[tlbpt_pkg::OFFSET_BITS-1:0];
			hit_q    <= 1'b0;
			fault_q  <= 1'b0;
			ev_q     <= 1'b0;
			evpage_q <= '0;
		end
		if (state_q == tlbpt_pkg::ST_TLB && tlb_hit) begin
			frame_q <= tlb_hit_frame;
			hit_q   <= 1'b1;
		end
		if (state_q == tlbpt_pkg::ST_PM_CHK) begin
			if (pm_rd_q.valid) begin
				frame_q <= pm_rd_q.frame;
			end else begin
				fault_q <= 1'b1;
				frame_q <= (free_q != '0) ? used[tlbpt_pkg::FRAME_BITS-1:0] : fifo_q;
			end
		end
		if (state_q == tlbpt_pkg::ST_LRU_SCAN) begin
			// Highest rank wins; strict compare keeps the lowest frame on a tie.
			if (pend_s1 && (idx_s1 == '0 || rank_rd_q > best_rank_q)) begin
				best_q      <= idx_s1;
				best_rank_q <= rank_rd_q;
			end
			if (scan_done)
				frame_q <= best_q;
		end
		if (state_q == tlbpt_pkg::ST_OWN_CHK) begin
			ev_q     <= 1'b1;
			evpage_q <= own_rd_q;
		end
		if (state_q == tlbpt_pkg::ST_TLB_FILL) begin
			if (fr_match) begin
				tlb_page_q[fr_idx] <= page_q;
			end else begin
				tlb_page_q[tlb_ptr_q]  <= page_q;
				tlb_frame_q[tlb_ptr_q] <= frame_q;
			end
		end
		if (state_q == tlbpt_pkg::ST_R_GET)
			r_q <= rank_rd_q;
		if (out_load)
			m_tdata_q <= {1'b0, evpage_q, ev_q, fault_q, hit_q, frame_q, off_q};
	end

	a_hit_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[18] && m_tdata[19]))
		else $error("translation flagged both TLB hit and page fault");

	a_evict_needs_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[20] |-> m_tdata[19] && free_q == '0)
		else $error("eviction reported without a fault on a full frame pool");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= tlbpt_pkg::count_t'(tlbpt_pkg::FRAME_COUNT))
		else $error("free frame count exceeds the frame pool");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tlbpt_pkg::ST_CLEAR |-> !s_tready)
		else $error("beat taken during the page map clearing pass");

endmodule
`default_nettype wire

// ===== tb/tlb_checker.sv =====
// Checker for the page translation block: predicts each translation and compares result beats.
`timescale 1ns / 1ps
module tlb_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	output int               fail_count,
	output int               pending,
	output int               hits,
	output int               faults,
	output int               evictions
);

	typedef struct {
		logic [tlbpt_pkg::PHYS_BITS-1:0] phys;
		logic                            hit;
		logic                            fault;
		logic                            ev_valid;
		tlbpt_pkg::page_t                ev_page;
	} xlate_t;

	xlate_t            xlate_q[$];
	logic              mode;
	logic              tlb_v  [tlbpt_pkg::TLB_ENTRIES];
	tlbpt_pkg::page_t  tlb_pg [tlbpt_pkg::TLB_ENTRIES];
	tlbpt_pkg::frame_t tlb_fr [tlbpt_pkg::TLB_ENTRIES];
	int                ins_ptr;
	logic              map_v  [tlbpt_pkg::PAGE_COUNT];
	tlbpt_pkg::frame_t map_fr [tlbpt_pkg::PAGE_COUNT];
	tlbpt_pkg::page_t  owner  [tlbpt_pkg::FRAME_COUNT];
	int                rank   [tlbpt_pkg::FRAME_COUNT];
	int                free_cnt;
	int                fifo_ptr;

	assign pending = xlate_q.size();

	function automatic xlate_t translate(input logic [tlbpt_pkg::ADDR_BITS-1:0] addr);
		xlate_t             r;
		tlbpt_pkg::page_t   pg;
		tlbpt_pkg::offset_t off;
		tlbpt_pkg::frame_t  fr;
		int                 used;
		int                 old;
		int                 best;
		bit                 done;
		pg = addr[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS];
		off = addr[tlbpt_pkg::OFFSET_BITS-1:0];
		fr = '0;
		r.hit = 1'b0;
		r.fault = 1'b0;
		r.ev_valid = 1'b0;
		r.ev_page = '0;
		for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
			if (!r.hit && tlb_v[i] && tlb_pg[i] == pg) begin
				fr = tlb_fr[i];
				r.hit = 1'b1;
			end
		end
		if (!r.hit) begin
			if (map_v[pg]) begin
				fr = map_fr[pg];
			end else begin
				r.fault = 1'b1;
				if (free_cnt > 0) begin
					fr = tlbpt_pkg::frame_t'(tlbpt_pkg::FRAME_COUNT - free_cnt);
					rank[fr] = tlbpt_pkg::FRAME_COUNT - free_cnt;
					free_cnt--;
				end else begin
					if (mode == tlbpt_pkg::MODE_LRU) begin
						best = 0;
						for (int g = 1; g < tlbpt_pkg::FRAME_COUNT; g++)
							if (rank[g] > rank[best]) best = g;
						fr = tlbpt_pkg::frame_t'(best);
					end else begin
						fr = tlbpt_pkg::frame_t'(fifo_ptr);
					end
					r.ev_page = owner[fr];
					r.ev_valid = 1'b1;
					map_v[r.ev_page] = 1'b0;
					map_fr[r.ev_page] = '0;
				end
				fifo_ptr = (fifo_ptr + 1) % tlbpt_pkg::FRAME_COUNT;
				map_v[pg] = 1'b1;
				map_fr[pg] = fr;
				owner[fr] = pg;
			end
			// A valid entry already holding this frame is retargeted to the new page.
			done = 0;
			for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
				if (!done && tlb_v[i] && tlb_fr[i] == fr) begin
					tlb_pg[i] = pg;
					done = 1;
				end
			end
			if (!done) begin
				tlb_v[ins_ptr] = 1'b1;
				tlb_pg[ins_ptr] = pg;
				tlb_fr[ins_ptr] = fr;
				ins_ptr = (ins_ptr + 1) % tlbpt_pkg::TLB_ENTRIES;
			end
		end
		used = tlbpt_pkg::FRAME_COUNT - free_cnt;
		old = rank[fr];
		for (int g = 0; g < used; g++)
			if (g != fr && rank[g] < old) rank[g]++;
		rank[fr] = 0;
		r.phys = {fr, off};
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		xlate_t e;
		xlate_t got;
		if (!arst_n) begin
			xlate_q.delete();
			mode = tlbpt_pkg::MODE_FIFO;
			ins_ptr = 0;
			free_cnt = tlbpt_pkg::FRAME_COUNT;
			fifo_ptr = 0;
			fail_count = 0;
			hits = 0;
			faults = 0;
			evictions = 0;
			for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++) begin
				tlb_v[i] = 1'b0;
				tlb_pg[i] = '0;
				tlb_fr[i] = '0;
			end
			for (int p = 0; p < tlbpt_pkg::PAGE_COUNT; p++) begin
				map_v[p] = 1'b0;
				map_fr[p] = '0;
			end
			for (int f = 0; f < tlbpt_pkg::FRAME_COUNT; f++) begin
				owner[f] = '0;
				rank[f] = 0;
			end
		end else begin
			if (cfg_wr_en) mode = cfg_wr_data;
			if (m_tvalid && m_tready) begin
				got.phys = m_tdata[17:0];
				got.hit = m_tdata[18];
				got.fault = m_tdata[19];
				got.ev_valid = m_tdata[20];
				got.ev_page = m_tdata[30:21];
				if (xlate_q.size() == 0) begin
					$error("result beat with no translation outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					e = xlate_q.pop_front();
					if (got.phys !== e.phys) begin
						$error("phys_addr expected %h actual %h", e.phys, got.phys);
						fail_count++;
					end
					if (got.hit !== e.hit) begin
						$error("tlb_hit expected %b actual %b", e.hit, got.hit);
						fail_count++;
					end
					if (got.fault !== e.fault) begin
						$error("page_fault expected %b actual %b", e.fault, got.fault);
						fail_count++;
					end
					if (got.ev_valid !== e.ev_valid) begin
						$error("evicted_valid expected %b actual %b", e.ev_valid,
							got.ev_valid);
						fail_count++;
					end
					if (got.ev_page !== e.ev_page) begin
						$error("evicted_page expected %h actual %h", e.ev_page,
							got.ev_page);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				e = translate(s_tdata[tlbpt_pkg::ADDR_BITS-1:0]);
				hits += e.hit;
				faults += e.fault;
				evictions += e.ev_valid;
				xlate_q.push_back(e);
			end
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: drives addresses and replacement mode, and reports the checker verdict.
`timescale 1ns / 1ps
module testbench;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int LONG_HOLD   = 3000;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [23:0]      s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [31:0]      m_tdata;
	logic             cfg_wr_en;
	logic             cfg_wr_data;
	int               fail_count;
	int               pending;
	int               hits;
	int               faults;
	int               evictions;
	int               cycles;
	int               items;
	bit               tx_idle_on;
	bit               rx_idle_on;
	bit               hold_go;
	tlbpt_pkg::page_t recent [32];
	int               recent_wr;

	tlb_page_translation_with_replacement u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	tlb_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count (fail_count),
		.pending    (pending),
		.hits       (hits),
		.faults     (faults),
		.evictions  (evictions)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken, or later when an idle gap is drawn.
	task automatic send_addr(input logic [tlbpt_pkg::ADDR_BITS-1:0] addr);
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, addr};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		items++;
		recent[recent_wr] = addr[tlbpt_pkg::ADDR_BITS-1:tlbpt_pkg::OFFSET_BITS];
		recent_wr = (recent_wr + 1) % 32;
		if (tx_idle_on && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	task automatic drain_and_set_mode(input logic m);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (10) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Mix of recently used pages, which mostly hit, and fresh random pages that may fault.
	task automatic random_run(input int n, input int reuse_pct);
		tlbpt_pkg::page_t pg;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < reuse_pct)
				pg = recent[$urandom_range(0, 31)];
			else
				pg = tlbpt_pkg::page_t'($urandom);
			send_addr({pg, tlbpt_pkg::offset_t'($urandom)});
		end
	endtask

	always begin
		@(negedge clk);
		if (hold_go) begin
			hold_go = 0;
			m_tready <= 1'b0;
			repeat (LONG_HOLD) @(negedge clk);
			m_tready <= 1'b1;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		cycles = 0;
		items = 0;
		recent_wr = 0;
		for (int i = 0; i < 32; i++) recent[i] = '0;
		tx_idle_on = 1;
		rx_idle_on = 1;
		hold_go = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		drain_and_set_mode(tlbpt_pkg::MODE_FIFO);

		// Address extremes, a repeat that hits the TLB, then enough pages to
		// push page zero out of the TLB so it resolves from the page map.
		send_addr(20'h00000);
		send_addr(20'hFFFFF);
		send_addr(20'h003FF);
		send_addr(20'hFFC00);
		send_addr(20'h00155);
		for (int p = 1; p <= 17; p++)
			send_addr({tlbpt_pkg::page_t'(p * 37), tlbpt_pkg::offset_t'(p)});
		send_addr(20'h002AA);
		send_addr(20'hFFFFF);

		// The long receiver hold fills the block while the sender keeps offering.
		hold_go = 1;
		random_run(280, 30);
		drain_and_set_mode(tlbpt_pkg::MODE_LRU);
		random_run(150, 50);
		drain_and_set_mode(tlbpt_pkg::MODE_FIFO);
		random_run(60, 40);
		drain_and_set_mode(tlbpt_pkg::MODE_LRU);
		tx_idle_on = 0;
		rx_idle_on = 0;
		random_run(60, 40);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (40) @(posedge clk);

		$display("Translated %0d addresses: %0d TLB hits, %0d faults, %0d evictions,",
			items, hits, faults, evictions);
		$display("under both FIFO and LRU replacement with mode changes between phases.");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
